// File: hdl/mavg_pkg.sv
package mavg_pkg;

  // default window limit
  localparam int MAX_TAPS_DEF = 64;

  // fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int TAP_CFG_W = 7;

  // register port
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_TAP_COUNT = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hdl/mavg_div.sv
module mavg_div #(
  parameter int SUM_W = 22,
  parameter int TC_W  = 7
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [SUM_W-1:0]              total,
  input  logic [TC_W-1:0]                      divisor,
  output mavg_pkg::div_stat_t                  stat,
  output logic signed [mavg_pkg::SAMPLE_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);
  localparam int SW    = mavg_pkg::SAMPLE_W;
  localparam logic [SUM_W-1:0] POS_LIM = SUM_W'((2 ** (SW - 1)) - 1);
  localparam logic [SUM_W-1:0] NEG_LIM = SUM_W'(2 ** (SW - 1));

  // restoring division, one quotient bit per cycle, MSB first
  logic [SUM_W-1:0] mag_r, mag_nxt;
  logic [TC_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic             busy_r;
  logic             done_r;
  logic [TC_W:0]    trial;
  logic             fits;

  always_comb begin
    trial   = {rem_r, mag_r[SUM_W-1]};
    fits    = trial >= {1'b0, divisor};
    rem_nxt = fits ? TC_W'(trial - {1'b0, divisor}) : TC_W'(trial);
    mag_nxt = {mag_r[SUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= total[SUM_W-1] ? SUM_W'(-total) : SUM_W'(total);
      neg_r <= total[SUM_W-1];
      rem_r <= '0;
    end else if (busy_r) begin
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
    end
  end

  // sign restore and clamp to the sample range
  always_comb begin
    if (neg_r) begin
      quotient = (mag_r > NEG_LIM) ? SW'(NEG_LIM) : SW'(-mag_r[SW-1:0]);
    end else begin
      quotient = (mag_r > POS_LIM) ? SW'(POS_LIM) : SW'(mag_r[SW-1:0]);
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: hdl/moving_average_filter_unit.sv
// Moving-average filter over signed 16-bit audio samples.
// Input channel: in_valid / in_stall / in_sample. A transaction completes at
// a rising edge with in_valid high and in_stall low. Output channel:
// out_valid / out_stall / out_average, one result transaction per input.
// The result is the window sum (this sample plus the previous tap_count-1)
// divided by tap_count, truncated toward zero and clamped to int16.
// Register port (APB style, pready always high): tap_count at address 0.
// A write clamps the value to 1..MAX_TAPS and clears the window history
// and running sum; write it only while the block is idle.
// Flow: one sample in flight at a time; no new sample is taken until
// the last result is loaded into the output register. A sample passes
// through the LOAD state, which updates the running sum and starts the
// divider, then the DIV state, in which the bit-serial divider resolves
// one quotient bit per cycle over the SUM_W-bit window sum.
// If the receiver stalls, the finished result waits in the output
// register; the next sample is still taken and divided, and its result
// then waits in the divider with in_stall high until the register frees.
// Reset: tap_count = 1, window empty, no result pending. The history
// memory is not cleared; a fill count marks which slots hold samples.
module moving_average_filter_unit #(
  parameter int MAX_TAPS = mavg_pkg::MAX_TAPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [mavg_pkg::SAMPLE_W-1:0] in_sample,
  // average output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mavg_pkg::SAMPLE_W-1:0] out_average,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mavg_pkg::PADDR_W-1:0]         paddr,
  input  logic [mavg_pkg::PDATA_W-1:0]         pwdata,
  output logic [mavg_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);

  localparam int SW     = mavg_pkg::SAMPLE_W;
  localparam int HIST_D = MAX_TAPS - 1;            // history depth
  localparam int WP_W   = $clog2(MAX_TAPS);        // ring index / fill count
  localparam int TC_W   = $clog2(MAX_TAPS + 1);    // holds 1..MAX_TAPS
  localparam int SUM_W  = SW + $clog2(MAX_TAPS);   // window sum, signed
  localparam int AW     = TC_W + 1;                // ring address arithmetic
  localparam int CMP_W  = (TC_W > mavg_pkg::TAP_CFG_W) ? TC_W : mavg_pkg::TAP_CFG_W;

  // ---------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------
  logic              cfg_wr;
  logic [CMP_W-1:0]  cfg_val;
  logic [TC_W-1:0]   cfg_taps;
  logic [TC_W-1:0]   tc_r;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr == mavg_pkg::ADDR_TAP_COUNT);
  assign cfg_val = CMP_W'(pwdata[mavg_pkg::TAP_CFG_W-1:0]);

  // zero reads as one, above the limit saturates
  always_comb begin
    if (cfg_val == '0) begin
      cfg_taps = TC_W'(1);
    end else if (cfg_val > CMP_W'(MAX_TAPS)) begin
      cfg_taps = TC_W'(MAX_TAPS);
    end else begin
      cfg_taps = TC_W'(cfg_val);
    end
  end

  assign prdata = (paddr == mavg_pkg::ADDR_TAP_COUNT) ? mavg_pkg::PDATA_W'(tc_r) : '0;

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  mavg_pkg::state_t    state_r, state_nxt;
  mavg_pkg::div_stat_t div_stat;
  logic                accept;
  logic                div_start;
  logic                out_free;
  logic                out_load;

  assign out_free = !out_valid || !out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      mavg_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = mavg_pkg::ST_LOAD;
        end
      end
      mavg_pkg::ST_LOAD: begin
        div_start = 1'b1;
        state_nxt = mavg_pkg::ST_DIV;
      end
      mavg_pkg::ST_DIV: begin
        if (div_stat.done) begin
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = mavg_pkg::ST_IDLE;
          end else begin
            state_nxt = mavg_pkg::ST_OUT;
          end
        end
      end
      mavg_pkg::ST_OUT: begin
        // result held in the divider until the output register frees
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = mavg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mavg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mavg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // window: history ring, fill count, running sum
  // ---------------------------------------------------------------------
  logic signed [SW-1:0]    hist_mem [HIST_D];
  logic signed [SW-1:0]    old_r;
  logic [WP_W-1:0]         wp_r, wp_nxt;
  logic [WP_W-1:0]         fc_r;
  logic [WP_W-1:0]         old_idx;
  logic [TC_W-1:0]         back;
  logic [AW-1:0]           wp_ext;
  logic [AW-1:0]           back_ext;
  logic                    old_ok_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] total_r;

  assign back     = tc_r - 1'b1;
  assign wp_ext   = AW'(wp_r);
  assign back_ext = AW'(back);
  assign wp_nxt   = (wp_r == WP_W'(HIST_D - 1)) ? '0 : wp_r + 1'b1;

  // slot of the sample leaving the window
  always_comb begin
    if (wp_ext >= back_ext) begin
      old_idx = WP_W'(wp_ext - back_ext);
    end else begin
      old_idx = WP_W'(wp_ext + AW'(HIST_D) - back_ext);
    end
  end

  // read before write: with a full window the leaving slot is the one written
  always_ff @(posedge clk) begin
    if (accept) begin
      old_r             <= hist_mem[old_idx];
      hist_mem[wp_r]    <= in_sample;
      total_r           <= sum_r + SUM_W'(in_sample);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r     <= TC_W'(1);
      wp_r     <= '0;
      fc_r     <= '0;
      sum_r    <= '0;
      old_ok_r <= 1'b0;
    end else if (cfg_wr) begin
      tc_r  <= cfg_taps;
      wp_r  <= '0;
      fc_r  <= '0;
      sum_r <= '0;
    end else begin
      if (accept) begin
        wp_r     <= wp_nxt;
        fc_r     <= (fc_r == WP_W'(HIST_D)) ? fc_r : fc_r + 1'b1;
        old_ok_r <= AW'(fc_r) >= back_ext;
      end
      // slots never written since the last clear count as zero
      if (state_r == mavg_pkg::ST_LOAD && back != '0) begin
        sum_r <= total_r - (old_ok_r ? SUM_W'(old_r) : SUM_W'(0));
      end
    end
  end

  // ---------------------------------------------------------------------
  // divider and output register
  // ---------------------------------------------------------------------
  logic signed [SW-1:0] quotient;
  logic                 out_valid_r;
  logic signed [SW-1:0] out_average_r;

  mavg_div #(
    .SUM_W (SUM_W),
    .TC_W  (TC_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .total    (total_r),
    .divisor  (tc_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_average_r <= quotient;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    AW'(fc_r) <= AW'(HIST_D))
    else $error("fill count past history depth");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    AW'(wp_r) < AW'(HIST_D))
    else $error("write pointer out of ring");

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == mavg_pkg::ST_LOAD)
    else $error("accepted sample not followed by load");

  a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == mavg_pkg::ST_DIV ||
                            $past(state_r) == mavg_pkg::ST_OUT))
    else $error("result loaded outside of divide completion");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int SAMPLE_W     = mavg_pkg::SAMPLE_W;
  localparam int TAP_CFG_W    = mavg_pkg::TAP_CFG_W;
  localparam int PADDR_W      = mavg_pkg::PADDR_W;
  localparam int PDATA_W      = mavg_pkg::PDATA_W;
  localparam int MAX_TAPS_DEF = mavg_pkg::MAX_TAPS_DEF;
  localparam logic [PADDR_W-1:0] ADDR_TAP_COUNT = mavg_pkg::ADDR_TAP_COUNT;

  // ring of past samples kept by the window: MAX_TAPS-1 deep
  localparam int HIST_DEPTH     = MAX_TAPS_DEF - 1;
  // drain margin once every expected average has come back
  localparam int SETTLE_CYCLES  = 40;
  // cycles with no transaction on any port before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_COUNT    = 10;
  localparam int PHASE_ITEMS    = 93;
  localparam int DIR_ROWS       = 23;
  localparam int INT16_MAX      = 32767;
  localparam int INT16_MIN      = -32768;
  // any address that decodes to no register
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 2'd2;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  // one line of the directed table; avg is used only when pinned is set
  typedef struct {
    row_kind_t                  kind;
    logic [PADDR_W-1:0]         addr;
    logic [PDATA_W-1:0]         data;
    logic                       pinned;
    logic signed [SAMPLE_W-1:0] avg;
  } dir_row_t;

  // character of the random sample stream
  typedef enum logic [2:0] {TONE_NOISE, TONE_TOP, TONE_BOTTOM, TONE_QUIET, TONE_SWING} tone_t;

  // receiver back-pressure modes
  typedef enum logic [1:0] {RX_FLOW, RX_CHOPPY, RX_SLUGGISH, RX_BEAT} rx_mode_t;

  logic                       clk;
  logic                       rst_n       = 1'b0;
  logic                       in_valid    = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample   = '0;
  logic                       out_valid;
  logic                       out_stall   = 1'b0;
  logic signed [SAMPLE_W-1:0] out_average;
  logic                       psel        = 1'b0;
  logic                       penable     = 1'b0;
  logic                       pwrite      = 1'b0;
  logic [PADDR_W-1:0]         paddr       = '0;
  logic [PDATA_W-1:0]         pwdata      = '0;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;

  // sideband that travels with each sample: a typed-in expected average
  logic                       pin_row     = 1'b0;
  logic signed [SAMPLE_W-1:0] pin_avg     = '0;

  // window model state
  int unsigned                win_taps;
  logic signed [SAMPLE_W-1:0] win_hist [HIST_DEPTH];
  logic signed [21:0]         win_sum;
  logic [5:0]                 win_wr;
  logic signed [SAMPLE_W-1:0] avg_expected [$];
  logic signed [SAMPLE_W-1:0] mean_now;
  logic signed [SAMPLE_W-1:0] avg_want;

  int          fail_count  = 0;
  int          idle_cycles = 0;
  rx_mode_t    rx_mode     = RX_FLOW;
  int          rx_left     = 0;
  int unsigned rx_tick     = 0;

  // Directed table. N=1 rows echo the sample; the window-of-two and
  // full-window rows are simple enough to type in. Rows left unpinned
  // go through the window model.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_0000, 1'b1, 16'sh0000},
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_7FFF, 1'b1, 16'sh7FFF},
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_8000, 1'b1, 16'sh8000},
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_FFFF, 1'b1, 16'shFFFF},
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_0001, 1'b1, 16'sh0001},
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_5555, 1'b1, 16'sh5555},
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_AAAA, 1'b1, 16'shAAAA},
    // write to an unmapped address: window stays at one
    '{ROW_WRITE,  ADDR_UNMAPPED,  32'h0000_0005, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_3039, 1'b1, 16'sh3039},
    // zero length reads as one
    '{ROW_WRITE,  ADDR_TAP_COUNT, 32'h0000_0000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_FFF9, 1'b1, 16'shFFF9},
    // window of two: -3/2 truncates toward zero
    '{ROW_WRITE,  ADDR_TAP_COUNT, 32'h0000_0002, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_FFFD, 1'b1, 16'shFFFF},
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_7FFF, 1'b1, 16'sh3FFE},
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_7FFF, 1'b1, 16'sh7FFF},
    // overlong length saturates to the full window
    '{ROW_WRITE,  ADDR_TAP_COUNT, 32'h0000_007F, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_8000, 1'b1, 16'shFE00},
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_8000, 1'b1, 16'shFC00},
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_003F, 1'b0, 16'sh0000},
    '{ROW_WRITE,  ADDR_TAP_COUNT, 32'h0000_0003, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_0005, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_FFFB, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, ADDR_TAP_COUNT, 32'h0000_FFFB, 1'b0, 16'sh0000}
  };

  // window lengths for the first random phases; the rest are random
  logic [TAP_CFG_W-1:0] tap_plan [6] = '{7'd64, 7'd1, 7'd127, 7'd2, 7'd0, 7'd63};

  moving_average_filter_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_average (out_average),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Window model
  // ---------------------------------------------------------------------

  function automatic void clear_window();
    foreach (win_hist[i]) win_hist[i] = '0;
    win_sum = '0;
    win_wr  = '0;
  endfunction

  // tap_count write: low 7 bits, clamped to 1..MAX_TAPS, history cleared
  function automatic void load_taps(input logic [PDATA_W-1:0] value);
    int unsigned n;
    n = value[TAP_CFG_W-1:0];
    if (n < 1) n = 1;
    if (n > MAX_TAPS_DEF) n = MAX_TAPS_DEF;
    win_taps = n;
    clear_window();
  endfunction

  // Mean of this sample and the previous N-1. win_sum holds the N-1 past
  // samples, so the oldest one drops out after the quotient is formed.
  function automatic logic signed [SAMPLE_W-1:0] window_mean(
    input logic signed [SAMPLE_W-1:0] x
  );
    int total;
    int q;
    int back;
    int oldest;
    total = int'(win_sum) + int'(x);
    q     = total / int'(win_taps);  // SV int division truncates toward zero
    if (q > INT16_MAX) q = INT16_MAX;
    if (q < INT16_MIN) q = INT16_MIN;
    back = int'(win_taps) - 1;
    if (back > 0) begin
      oldest  = (int'(win_wr) + HIST_DEPTH - back) % HIST_DEPTH;
      win_sum = 22'(int'(win_sum) - int'(win_hist[oldest]) + int'(x));
    end
    win_hist[win_wr] = x;
    win_wr = 6'((int'(win_wr) + 1) % HIST_DEPTH);
    return q[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] next_sample(input tone_t tone);
    case (tone)
      TONE_TOP:    return 16'sh7FFF;
      TONE_BOTTOM: return 16'sh8000;
      TONE_QUIET:  return 16'(int'($urandom_range(0, 16)) - 8);
      TONE_SWING:  return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default:     return 16'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Present one sample and hold it until the transaction completes.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] x, input logic pin,
                             input logic signed [SAMPLE_W-1:0] avg);
    in_valid  <= 1'b1;
    in_sample <= x;
    pin_row   <= pin;
    pin_avg   <= avg;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic sender_pause(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every outstanding average has come back.
  // It first lets the clock advance so the last accepted sample is already queued.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (avg_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access; pready ends the access.
  // The bus then idles so back-to-back writes start on a fresh edge.
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_TAP_COUNT) load_taps(data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Receiver back-pressure: modes of random duration, one of them a fixed
  // beat off a free-running counter, so stalls land on every divider phase.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(40, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FLOW:     out_stall <= 1'b0;
      RX_CHOPPY:   out_stall <= 1'($urandom_range(0, 1));
      RX_SLUGGISH: out_stall <= ($urandom_range(0, 7) != 0);
      default:     out_stall <= ((rx_tick % 37) < 19);
    endcase
  end

  // ---------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------

  // every accepted sample moves the window model; pinned rows override
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      mean_now = window_mean(in_sample);
      avg_expected.push_back(pin_row ? pin_avg : mean_now);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (avg_expected.size() == 0) begin
        $error("out_average: expected none, got %0d", out_average);
        fail_count++;
      end else begin
        avg_want = avg_expected.pop_front();
        if (out_average !== avg_want) begin
          $error("out_average: expected %0d, got %0d", avg_want, out_average);
          fail_count++;
        end
      end
    end
  end

  // hang detector: any transaction on any port restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("moving_average_filter_unit test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    int    ph;
    int    k;
    int    burst_left;
    int    seg_left;
    tone_t tone;
    logic [PDATA_W-1:0] wr;

    // model starts where reset leaves the block: N = 1, empty window
    win_taps = 1;
    clear_window();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; register writes only with the pipe drained
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        quiesce();
        apb_write(dir_rows[r].addr, dir_rows[r].data);
      end else begin
        push_sample(dir_rows[r].data[SAMPLE_W-1:0], dir_rows[r].pinned, dir_rows[r].avg);
        sender_pause($urandom_range(0, 2));
      end
    end

    // Random phases. Each opens with a run of one extreme longer than the
    // full window, so the sum reaches its limits, then mixes segments of
    // noise, quiet, swing and extreme runs. Sender works in bursts.
    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      quiesce();
      if ($urandom_range(0, 2) == 0) apb_write(2'($urandom_range(1, 3)), $urandom());
      wr = $urandom();  // upper bits random, only the low 7 count
      wr[TAP_CFG_W-1:0] = (ph < 6) ? tap_plan[ph] : 7'($urandom_range(0, 127));
      apb_write(ADDR_TAP_COUNT, wr);

      tone       = $urandom_range(0, 1) ? TONE_TOP : TONE_BOTTOM;
      seg_left   = MAX_TAPS_DEF + 8;
      burst_left = $urandom_range(1, 40);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (seg_left == 0) begin
          tone     = tone_t'($urandom_range(0, 4));
          seg_left = $urandom_range(8, 100);
        end
        seg_left--;
        push_sample(next_sample(tone), 1'b0, '0);
        if (burst_left == 0) begin
          // a quarter of bursts run straight into the next one
          sender_pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30));
          burst_left = $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end
    end

    quiesce();
    if (fail_count == 0) begin
      $display("moving_average_filter_unit test passed");
    end else begin
      $display("moving_average_filter_unit test failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/mavg_pkg.sv
hdl/mavg_div.sv
hdl/moving_average_filter_unit.sv
tb/sv/tb.sv
